// ===== sv/dsm_pkg.sv =====
// dsm_pkg: shared constants and types of the duration text parser
// used by the channel interfaces and duration_string_to_ms_top; no dependencies

package dsm_pkg;

  // accumulator width; totals above its maximum are flagged invalid
  localparam int RESULT_BITS = 32;
  localparam int ACC_W       = RESULT_BITS;
  localparam int MILLIS_W    = 32;
  localparam int CH_W        = 8;
  localparam int COLON_W     = 2;
  localparam int FRAC_W      = 10;
  localparam int FDIG_W      = 2;
  localparam int DIGIT_W     = 4;

  // widths of the exact intermediates: x*10+d, x*60+y, x*1000+f
  localparam int CUR_EXT_W = ACC_W + 4;
  localparam int TOT1_W    = ACC_W + 7;
  localparam int TOT2_W    = ACC_W + 11;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  localparam int DEC_BASE    = 10;
  localparam int SEXAGESIMAL = 60;
  localparam int MS_PER_S    = 1000;
  localparam int MS_TENTHS   = 100;
  localparam int MS_HUNDREDS = 10;

  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CH_W-1:0] CH_POINT  = 8'h2E;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;

  localparam logic [COLON_W-1:0] COLONS_NONE = 2'd0;
  localparam logic [COLON_W-1:0] COLONS_ONE  = 2'd1;
  localparam logic [COLON_W-1:0] COLONS_MAX  = 2'd2;

  localparam logic [FDIG_W-1:0] FDIG_TENTHS   = 2'd0;
  localparam logic [FDIG_W-1:0] FDIG_HUNDREDS = 2'd1;
  localparam logic [FDIG_W-1:0] FDIG_THOUS    = 2'd2;
  localparam logic [FDIG_W-1:0] FDIG_FULL     = 2'd3;

  typedef enum logic [2:0] {
    PH_INT  = 3'b001,
    PH_FRAC = 3'b010,
    PH_ERR  = 3'b100
  } phase_t;

endpackage

// ===== sv/dsm_text_if.sv =====
// dsm_text_if: character channel into the duration parser
// depends on dsm_pkg

interface dsm_text_if;
  logic                     valid;
  logic                     ready;
  logic [dsm_pkg::CH_W-1:0] ch;
  logic                     last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== sv/dsm_result_if.sv =====
// dsm_result_if: result channel out of the duration parser
// depends on dsm_pkg

interface dsm_result_if;
  logic                         valid;
  logic                         ready;
  logic [dsm_pkg::MILLIS_W-1:0] millis;
  logic                         valid_res;

  modport source (output valid, output millis, output valid_res, input ready);
  modport sink   (input valid, input millis, input valid_res, output ready);
endinterface

// ===== sv/duration_string_to_ms_top.sv =====
// Duration text parser: takes a text such as [[h:]m:]s[.fff] one character per word,
// the final character flagged by last, and returns one result word per text holding
// the duration in milliseconds and a valid flag (millis is zero when invalid). A comma
// works as decimal point, fraction digits beyond the third are dropped, every field but
// an hours field must be below 60, and a total above RESULT_BITS bits is invalid.
// One character is taken every cycle while results drain. With the output stalled,
// characters keep being taken until a final character finds both closing stages and the
// output register full; it then waits in the character register. After the character register
// takes the last character, the result passes through both closing stages and the output
// register: the closing fold (fields times 60, then times 1000 plus the fraction) is spread
// over two registered stages ahead of the output register.
// depends on dsm_pkg, dsm_text_if, dsm_result_if

module duration_string_to_ms_top (
  input  logic          clk,
  input  logic          rst,
  dsm_text_if.sink      text,
  dsm_result_if.source  result
);

  // input register
  logic                         v0;
  logic [dsm_pkg::CH_W-1:0]     ch0;
  logic                         last0;

  // parser state
  dsm_pkg::phase_t              phase, ph_next;
  logic [dsm_pkg::COLON_W-1:0]  colons, colons_next;
  logic [dsm_pkg::ACC_W-1:0]    earlier, earlier_next;
  logic [dsm_pkg::ACC_W-1:0]    cur, cur_next;
  logic                         lead_big, lead_big_next;
  logic [dsm_pkg::FRAC_W-1:0]   frac_ms, frac_next;
  logic [dsm_pkg::FDIG_W-1:0]   fdig, fdig_next;
  logic                         ovf, ovf_next;

  // closing stages
  logic                         v2, v3, vo;
  logic [dsm_pkg::ACC_W-1:0]    s2_earlier, s2_cur;
  logic [dsm_pkg::FRAC_W-1:0]   s2_frac, s3_frac;
  logic                         s2_ok, s2_ovf, s3_ok, s3_ovf;
  logic [dsm_pkg::ACC_W-1:0]    s3_t1;
  logic [dsm_pkg::MILLIS_W-1:0] out_millis;
  logic                         out_ok;

  logic                         en_out, ready3, ready2, consume0;
  logic                         is_digit;
  logic [dsm_pkg::DIGIT_W-1:0]  digit;
  logic [dsm_pkg::CUR_EXT_W-1:0] cur_mac;
  logic [dsm_pkg::TOT1_W-1:0]   col_mac, t1_mac;
  logic [dsm_pkg::TOT2_W-1:0]   t2_mac;
  logic                         t1_over, t2_over, ok_pre;
  logic [dsm_pkg::ACC_W-1:0]    t2_sat;

  // elastic handshake through the closing stages
  assign en_out   = !vo || result.ready;
  assign ready3   = !v3 || en_out;
  assign ready2   = !v2 || ready3;
  assign consume0 = v0 && (!last0 || ready2);
  assign text.ready = !v0 || consume0;

  assign is_digit = (ch0 >= dsm_pkg::CH_ZERO) && (ch0 <= dsm_pkg::CH_NINE);
  assign digit    = ch0[dsm_pkg::DIGIT_W-1:0];

  assign cur_mac = {4'b0, cur} * dsm_pkg::CUR_EXT_W'(dsm_pkg::DEC_BASE)
                 + dsm_pkg::CUR_EXT_W'(digit);
  assign col_mac = dsm_pkg::TOT1_W'(earlier) * dsm_pkg::TOT1_W'(dsm_pkg::SEXAGESIMAL)
                 + dsm_pkg::TOT1_W'(cur);

  always_comb begin
    ph_next       = phase;
    colons_next   = colons;
    earlier_next  = earlier;
    cur_next      = cur;
    lead_big_next = lead_big;
    frac_next     = frac_ms;
    fdig_next     = fdig;
    ovf_next      = ovf;
    unique case (phase)
      dsm_pkg::PH_INT: begin
        priority if (is_digit) begin
          if (cur_mac > dsm_pkg::CUR_EXT_W'(dsm_pkg::ACC_MAX)) begin
            ovf_next = 1'b1;
            cur_next = dsm_pkg::ACC_MAX;
          end else begin
            cur_next = cur_mac[dsm_pkg::ACC_W-1:0];
          end
        end else if (ch0 == dsm_pkg::CH_COLON) begin
          if (colons == dsm_pkg::COLONS_MAX) begin
            ph_next = dsm_pkg::PH_ERR;
          end else begin
            if (colons == dsm_pkg::COLONS_NONE) begin
              lead_big_next = cur >= dsm_pkg::ACC_W'(dsm_pkg::SEXAGESIMAL);
            end else if (cur >= dsm_pkg::ACC_W'(dsm_pkg::SEXAGESIMAL)) begin
              ph_next = dsm_pkg::PH_ERR;
            end
            if (col_mac > dsm_pkg::TOT1_W'(dsm_pkg::ACC_MAX)) begin
              ovf_next     = 1'b1;
              earlier_next = dsm_pkg::ACC_MAX;
            end else begin
              earlier_next = col_mac[dsm_pkg::ACC_W-1:0];
            end
            cur_next    = '0;
            colons_next = colons + dsm_pkg::COLONS_ONE;
          end
        end else if (ch0 == dsm_pkg::CH_POINT || ch0 == dsm_pkg::CH_COMMA) begin
          ph_next = dsm_pkg::PH_FRAC;
        end else begin
          ph_next = dsm_pkg::PH_ERR;
        end
      end
      dsm_pkg::PH_FRAC: begin
        if (is_digit) begin
          unique case (fdig)
            dsm_pkg::FDIG_TENTHS:
              frac_next = frac_ms
                        + dsm_pkg::FRAC_W'(digit) * dsm_pkg::FRAC_W'(dsm_pkg::MS_TENTHS);
            dsm_pkg::FDIG_HUNDREDS:
              frac_next = frac_ms
                        + dsm_pkg::FRAC_W'(digit) * dsm_pkg::FRAC_W'(dsm_pkg::MS_HUNDREDS);
            dsm_pkg::FDIG_THOUS:
              frac_next = frac_ms + dsm_pkg::FRAC_W'(digit);
            default: frac_next = frac_ms;
          endcase
          if (fdig != dsm_pkg::FDIG_FULL) begin
            fdig_next = fdig + 2'd1;
          end
        end else begin
          ph_next = dsm_pkg::PH_ERR;
        end
      end
      dsm_pkg::PH_ERR: ;
      default: ph_next = dsm_pkg::PH_ERR;
    endcase
  end

  assign ok_pre = (ph_next != dsm_pkg::PH_ERR)
               && (cur_next < dsm_pkg::ACC_W'(dsm_pkg::SEXAGESIMAL))
               && !(colons_next == dsm_pkg::COLONS_ONE && lead_big_next);

  // input register and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (text.ready) begin
      v0 <= text.valid;
    end
    if (text.ready && text.valid) begin
      ch0   <= text.ch;
      last0 <= text.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (consume0 && last0)) begin
      phase    <= dsm_pkg::PH_INT;
      colons   <= dsm_pkg::COLONS_NONE;
      earlier  <= '0;
      cur      <= '0;
      lead_big <= 1'b0;
      frac_ms  <= '0;
      fdig     <= dsm_pkg::FDIG_TENTHS;
      ovf      <= 1'b0;
    end else if (consume0) begin
      phase    <= ph_next;
      colons   <= colons_next;
      earlier  <= earlier_next;
      cur      <= cur_next;
      lead_big <= lead_big_next;
      frac_ms  <= frac_next;
      fdig     <= fdig_next;
      ovf      <= ovf_next;
    end
  end

  // snapshot of the finished text
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= consume0 && last0;
    end
    if (ready2 && consume0 && last0) begin
      s2_earlier <= earlier_next;
      s2_cur     <= cur_next;
      s2_frac    <= frac_next;
      s2_ok      <= ok_pre;
      s2_ovf     <= ovf_next;
    end
  end

  // fold the last field in: fields * 60 + seconds
  assign t1_mac  = dsm_pkg::TOT1_W'(s2_earlier) * dsm_pkg::TOT1_W'(dsm_pkg::SEXAGESIMAL)
                 + dsm_pkg::TOT1_W'(s2_cur);
  assign t1_over = t1_mac > dsm_pkg::TOT1_W'(dsm_pkg::ACC_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
    if (ready3 && v2) begin
      s3_t1   <= t1_over ? dsm_pkg::ACC_MAX : t1_mac[dsm_pkg::ACC_W-1:0];
      s3_frac <= s2_frac;
      s3_ok   <= s2_ok;
      s3_ovf  <= s2_ovf || t1_over;
    end
  end

  // seconds to milliseconds plus the fraction
  assign t2_mac  = dsm_pkg::TOT2_W'(s3_t1) * dsm_pkg::TOT2_W'(dsm_pkg::MS_PER_S)
                 + dsm_pkg::TOT2_W'(s3_frac);
  assign t2_over = t2_mac > dsm_pkg::TOT2_W'(dsm_pkg::ACC_MAX);
  assign t2_sat  = t2_mac[dsm_pkg::ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en_out) begin
      vo <= v3;
    end
    if (en_out && v3) begin
      out_ok     <= s3_ok && !s3_ovf && !t2_over;
      out_millis <= (s3_ok && !s3_ovf && !t2_over) ? dsm_pkg::MILLIS_W'(t2_sat) : '0;
    end
  end

  assign result.valid     = vo;
  assign result.millis    = out_millis;
  assign result.valid_res = out_ok;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.valid_res |-> result.millis == '0)
    else $error("invalid result carries nonzero millis");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    consume0 && last0 |=> phase == dsm_pkg::PH_INT && colons == dsm_pkg::COLONS_NONE
                          && cur == '0 && earlier == '0 && !ovf)
    else $error("parser state not cleared after final character");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    frac_ms < dsm_pkg::FRAC_W'(dsm_pkg::MS_PER_S))
    else $error("fraction accumulator out of range");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !ready3 |=> v2 && $stable(s2_cur) && $stable(s2_earlier))
    else $error("closing stage lost a word while blocked");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    v0 && last0 && !ready2 |-> !text.ready)
    else $error("character taken while final word cannot advance");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: directed and random duration texts driven through duration_string_to_ms_top,
// each result word checked against an in-bench parser model held by a scoreboard class
// depends on dsm_pkg, dsm_text_if, dsm_result_if and the top level
`timescale 1ns / 100ps

module testbench;

  localparam int TEXT_CHARS     = 1000;
  localparam int CALM_CHARS     = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int REPORT_LIMIT   = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int WIDE_W         = dsm_pkg::ACC_W + 12;

  typedef logic [dsm_pkg::CH_W-1:0]     char_t;
  typedef logic [dsm_pkg::ACC_W-1:0]    acc_t;
  typedef logic [WIDE_W-1:0]            wide_t;
  typedef logic [dsm_pkg::MILLIS_W-1:0] millis_t;

  typedef struct packed {
    millis_t millis;
    logic    valid_res;
  } duration_t;

  class duration_scoreboard;
    duration_t                   expected_durations[$];
    int                          mismatches;
    dsm_pkg::phase_t             phase;
    logic [dsm_pkg::COLON_W-1:0] colons;
    acc_t                        closed_total;
    acc_t                        field_value;
    bit                          leading_big;
    logic [dsm_pkg::FRAC_W-1:0]  frac_ms;
    logic [dsm_pkg::FDIG_W-1:0]  frac_count;
    bit                          overflow;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase        = dsm_pkg::PH_INT;
      colons       = dsm_pkg::COLONS_NONE;
      closed_total = '0;
      field_value  = '0;
      leading_big  = 1'b0;
      frac_ms      = '0;
      frac_count   = dsm_pkg::FDIG_TENTHS;
      overflow     = 1'b0;
    endfunction

    // a * m + b, saturating at the accumulator maximum
    function acc_t fold(acc_t a, int unsigned m, acc_t b);
      wide_t wide;
      wide = wide_t'(a) * wide_t'(m) + wide_t'(b);
      if (wide > wide_t'(dsm_pkg::ACC_MAX)) begin
        overflow = 1'b1;
        return dsm_pkg::ACC_MAX;
      end
      return acc_t'(wide);
    endfunction

    function void note_char(char_t c, logic is_last);
      bit        is_digit;
      logic [3:0] d;
      acc_t      total;
      bit        ok;
      duration_t res;
      is_digit = c >= dsm_pkg::CH_ZERO && c <= dsm_pkg::CH_NINE;
      d = 4'(c - dsm_pkg::CH_ZERO);
      case (phase)
        dsm_pkg::PH_INT: begin
          if (is_digit) begin
            field_value = fold(field_value, dsm_pkg::DEC_BASE, acc_t'(d));
          end else if (c == dsm_pkg::CH_COLON) begin
            if (colons == dsm_pkg::COLONS_MAX) begin
              phase = dsm_pkg::PH_ERR;
            end else begin
              // the first field is only bounded once we know it is minutes
              if (colons == dsm_pkg::COLONS_NONE)
                leading_big = field_value >= dsm_pkg::SEXAGESIMAL;
              else if (field_value >= dsm_pkg::SEXAGESIMAL)
                phase = dsm_pkg::PH_ERR;
              closed_total = fold(closed_total, dsm_pkg::SEXAGESIMAL, field_value);
              field_value  = '0;
              colons++;
            end
          end else if (c == dsm_pkg::CH_POINT || c == dsm_pkg::CH_COMMA) begin
            phase = dsm_pkg::PH_FRAC;
          end else begin
            phase = dsm_pkg::PH_ERR;
          end
        end
        dsm_pkg::PH_FRAC: begin
          if (is_digit) begin
            case (frac_count)
              dsm_pkg::FDIG_TENTHS:
                frac_ms = frac_ms
                        + dsm_pkg::FRAC_W'(d) * dsm_pkg::FRAC_W'(dsm_pkg::MS_TENTHS);
              dsm_pkg::FDIG_HUNDREDS:
                frac_ms = frac_ms
                        + dsm_pkg::FRAC_W'(d) * dsm_pkg::FRAC_W'(dsm_pkg::MS_HUNDREDS);
              dsm_pkg::FDIG_THOUS:
                frac_ms = frac_ms + dsm_pkg::FRAC_W'(d);
              default: ;
            endcase
            if (frac_count != dsm_pkg::FDIG_FULL)
              frac_count++;
          end else begin
            phase = dsm_pkg::PH_ERR;
          end
        end
        default: ;
      endcase
      if (!is_last)
        return;
      ok = phase != dsm_pkg::PH_ERR && field_value < dsm_pkg::SEXAGESIMAL &&
           !(colons == dsm_pkg::COLONS_ONE && leading_big);
      total = fold(closed_total, dsm_pkg::SEXAGESIMAL, field_value);
      total = fold(total, dsm_pkg::MS_PER_S, acc_t'(frac_ms));
      ok = ok && !overflow;
      res.millis    = ok ? millis_t'(total) : '0;
      res.valid_res = ok;
      expected_durations.push_back(res);
      clear();
    endfunction

    function void flag(string what, duration_t want, millis_t got_ms, logic got_ok);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t %s: expected millis=%0d valid=%0b, actual millis=%0d valid=%0b",
                 $time, what, want.millis, want.valid_res, got_ms, got_ok);
    endfunction

    function void check_result(millis_t got_ms, logic got_ok);
      duration_t want;
      if (expected_durations.size() == 0) begin
        want = '0;
        flag("result word with none pending", want, got_ms, got_ok);
        return;
      end
      want = expected_durations.pop_front();
      if (want.millis !== got_ms || want.valid_res !== got_ok)
        flag("result word differs", want, got_ms, got_ok);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  dsm_text_if   text_ch();
  dsm_result_if result_ch();

  duration_string_to_ms_top uut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  duration_scoreboard board;
  char_t              cur_text[$];
  int                 sent_chars  = 0;
  bit                 calm        = 1'b0;
  int                 stall_left  = 0;
  int                 idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: check each accepted word, stall in random bursts
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      board.check_result(result_ch.millis, result_ch.valid_res);
    if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_char(input char_t c, input logic is_last);
    if (!calm && $urandom_range(0, 6) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.ch    <= c;
    text_ch.last  <= is_last;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    board.note_char(c, is_last);
    sent_chars++;
    calm = sent_chars >= TEXT_CHARS - CALM_CHARS;
  endtask

  task automatic send_text();
    foreach (cur_text[i])
      send_char(cur_text[i], i == cur_text.size() - 1);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++)
      cur_text.push_back(char_t'(s[i]));
  endtask

  task automatic push_digits(input int count);
    repeat (count)
      cur_text.push_back(char_t'(dsm_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic build_wellformed();
    int fields;
    int pick;
    fields = $urandom_range(1, 3);
    for (int f = 0; f < fields; f++) begin
      if (f > 0)
        cur_text.push_back(dsm_pkg::CH_COLON);
      pick = $urandom_range(0, 11);
      if (pick == 3)
        continue;  // empty field
      if (f == 0 && fields == 3 && pick < 3)
        push_str($sformatf("%0d", $urandom_range(60, 1500)));
      else if (pick == 4)
        push_str($sformatf("%0d", $urandom_range(60, 99)));
      else if (pick == 5)
        push_str($sformatf("0%0d", $urandom_range(0, 9)));
      else
        push_str($sformatf("%0d", $urandom_range(0, 59)));
    end
    if ($urandom_range(0, 2) != 0) begin
      cur_text.push_back($urandom_range(0, 1) ? dsm_pkg::CH_POINT : dsm_pkg::CH_COMMA);
      push_digits($urandom_range(0, 5));
    end
    if (cur_text.size() == 0)
      push_digits(1);
  endtask

  task automatic build_random_text();
    int kind;
    int pos;
    cur_text.delete();
    kind = $urandom_range(0, 19);
    if (kind < 11) begin
      build_wellformed();
    end else if (kind < 14) begin
      // hours near the top of the 32-bit millisecond range
      if (kind == 13)
        push_str($sformatf("1193:02:47.%0d", $urandom_range(290, 299)));
      else
        push_str($sformatf("%0d:%02d:%02d", $urandom_range(1190, 1196),
                           $urandom_range(0, 59), $urandom_range(0, 59)));
      if (kind == 12)
        push_str($sformatf(".%03d", $urandom_range(0, 999)));
    end else if (kind < 16) begin
      // long digit runs saturate the field or the fold
      push_digits($urandom_range(8, 12));
      if (kind == 15)
        push_str(":0:0");
    end else if (kind < 18) begin
      build_wellformed();
      pos = $urandom_range(0, cur_text.size() - 1);
      cur_text[pos] = char_t'($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(1, 6))
        cur_text.push_back(char_t'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_directed();
    string texts[10];
    texts = '{".", "::5", ".5", "9,1234", "60:0", ":::", "1.2:", "99::", "59:59", "1:60:0"};
    foreach (texts[i]) begin
      cur_text.delete();
      push_str(texts[i]);
      send_text();
    end
    // both ends of the character range
    cur_text.delete();
    cur_text.push_back(8'h00);
    send_text();
    cur_text.delete();
    cur_text.push_back(8'hFF);
    send_text();
  endtask

  initial begin
    board = new();
    rst             <= 1'b1;
    text_ch.valid   <= 1'b0;
    text_ch.ch      <= '0;
    text_ch.last    <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    while (sent_chars < TEXT_CHARS) begin
      build_random_text();
      send_text();
    end
    text_ch.valid <= 1'b0;
    while (board.expected_durations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_durations.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
